// ----- rtl/core/ahik_pkg.sv -----
`default_nettype none

package ahik_pkg;

    localparam int LEN_W        = 16;  // Q2.14 lengths and heights
    localparam int ANG_W        = 16;  // Q3.13 angles
    localparam int V_W          = 18;  // height offset from the shoulder
    localparam int M_W          = 17;  // second link plus elbow offset
    localparam int RAD_W        = 36;  // square-root operand
    localparam int ROOT_W       = 18;  // square-root result
    localparam int CORDIC_STEPS = 20;
    localparam int CW           = 46;  // CORDIC x/y datapath
    localparam int ZW           = 24;  // CORDIC angle, Q3.20
    localparam int PRESCALE_SH  = 24;
    localparam int ANG_DROP     = 7;   // Q3.20 -> Q3.13

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;

    localparam logic [2:0] CFG_BASE  = 3'd0;
    localparam logic [2:0] CFG_LINK1 = 3'd1;
    localparam logic [2:0] CFG_ELBOW = 3'd2;
    localparam logic [2:0] CFG_LINK2 = 3'd3;
    localparam logic [2:0] CFG_GRIP  = 3'd4;

    typedef struct packed {
        logic [1:0]            status;
        logic                  tilt;
        logic signed [V_W-1:0] v;     // dz when tilting, dz - l1 when lifting
    } side_t;

    // atan(2^-i), Q3.20
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = 24'sd823550;
            5'd1:    r = 24'sd486170;
            5'd2:    r = 24'sd256879;
            5'd3:    r = 24'sd130396;
            5'd4:    r = 24'sd65451;
            5'd5:    r = 24'sd32757;
            5'd6:    r = 24'sd16383;
            5'd7:    r = 24'sd8192;
            5'd8:    r = 24'sd4096;
            5'd9:    r = 24'sd2048;
            5'd10:   r = 24'sd1024;
            5'd11:   r = 24'sd512;
            5'd12:   r = 24'sd256;
            5'd13:   r = 24'sd128;
            5'd14:   r = 24'sd64;
            5'd15:   r = 24'sd32;
            5'd16:   r = 24'sd16;
            5'd17:   r = 24'sd8;
            5'd18:   r = 24'sd4;
            5'd19:   r = 24'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ahik_sqrt.sv -----
`default_nettype none

// Floor square root, one result bit per stage.
module ahik_sqrt import ahik_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire side_t             in_side,
    input  wire logic [RAD_W-1:0]  in_rad,
    output logic                   out_valid,
    output side_t                  out_side,
    output logic [ROOT_W-1:0]      out_root
);

    localparam int RE = RAD_W + 2;

    logic [ROOT_W:1]     vld_reg;
    logic [RE-1:0]       rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [1:ROOT_W];
    side_t               side_reg [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int J = ROOT_W - 1 - k;
        logic              cur_vld;
        logic [RE-1:0]     cur_rem;
        logic [ROOT_W-1:0] cur_root;
        side_t             cur_side;
        logic [RE-1:0]     trial;

        if (k == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_rem  = {2'b00, in_rad};
            assign cur_root = '0;
            assign cur_side = in_side;
        end else begin : g_next
            assign cur_vld  = vld_reg[k];
            assign cur_rem  = rem_reg[k];
            assign cur_root = root_reg[k];
            assign cur_side = side_reg[k];
        end

        // (R + 2^J)^2 - R^2
        assign trial = ({{(RE-ROOT_W){1'b0}}, cur_root} << (J + 1)) + (RE'(1) << (2 * J));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= cur_side;
                if (cur_rem >= trial) begin
                    rem_reg[k+1]  <= cur_rem - trial;
                    root_reg[k+1] <= cur_root | (ROOT_W'(1) << J);
                end else begin
                    rem_reg[k+1]  <= cur_rem;
                    root_reg[k+1] <= cur_root;
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];

endmodule

`default_nettype wire

// ----- rtl/core/ahik_cordic.sv -----
`default_nettype none

// Two vectoring CORDIC lanes side by side, one step per stage.
// Lane A: atan(l1, m) when tilting, else zero. Lane B: atan(v, w).
module ahik_cordic import ahik_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire side_t              in_side,
    input  wire logic [ROOT_W-1:0]  in_w,
    input  wire logic [LEN_W-1:0]   l1,
    input  wire logic [M_W-1:0]     m,
    output logic                    out_valid,
    output side_t                   out_side,
    output logic [ROOT_W-1:0]       out_w,
    output logic signed [ZW-1:0]    out_za,
    output logic signed [ZW-1:0]    out_zb
);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    function automatic vec_t cstep(input vec_t c, input int unsigned i);
        vec_t n;
        n = c;
        if (c.y > 0) begin
            n.x = c.x + (c.y >>> i);
            n.y = c.y - (c.x >>> i);
            n.z = c.z + atan_tab(5'(i));
        end else if (c.y < 0) begin
            n.x = c.x - (c.y >>> i);
            n.y = c.y + (c.x >>> i);
            n.z = c.z - atan_tab(5'(i));
        end
        return n;
    endfunction

    logic [CORDIC_STEPS:1] vld_reg;
    vec_t                  a_reg    [1:CORDIC_STEPS];
    vec_t                  b_reg    [1:CORDIC_STEPS];
    side_t                 side_reg [1:CORDIC_STEPS];
    logic [ROOT_W-1:0]     w_reg    [1:CORDIC_STEPS];

    vec_t a_init;
    vec_t b_init;

    always_comb begin
        a_init.x = in_side.tilt ? ($signed({{(CW-M_W){1'b0}}, m}) <<< PRESCALE_SH) : '0;
        a_init.y = in_side.tilt ? ($signed({{(CW-LEN_W){1'b0}}, l1}) <<< PRESCALE_SH) : '0;
        a_init.z = '0;
        b_init.x = $signed({{(CW-ROOT_W){1'b0}}, in_w}) <<< PRESCALE_SH;
        b_init.y = $signed({{(CW-V_W){in_side.v[V_W-1]}}, in_side.v}) <<< PRESCALE_SH;
        b_init.z = '0;
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic              cur_vld;
        vec_t              cur_a;
        vec_t              cur_b;
        side_t             cur_side;
        logic [ROOT_W-1:0] cur_w;

        if (k == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_a    = a_init;
            assign cur_b    = b_init;
            assign cur_side = in_side;
            assign cur_w    = in_w;
        end else begin : g_next
            assign cur_vld  = vld_reg[k];
            assign cur_a    = a_reg[k];
            assign cur_b    = b_reg[k];
            assign cur_side = side_reg[k];
            assign cur_w    = w_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[k+1]    <= cstep(cur_a, k);
                b_reg[k+1]    <= cstep(cur_b, k);
                side_reg[k+1] <= cur_side;
                w_reg[k+1]    <= cur_w;
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];
    assign out_w     = w_reg[CORDIC_STEPS];
    assign out_za    = a_reg[CORDIC_STEPS].z;
    assign out_zb    = b_reg[CORDIC_STEPS].z;

endmodule

`default_nettype wire

// ----- rtl/core/arm_height_inverse_kinematics_unit.sv -----
// Registered pipeline from a word accepted on s_ to m_tvalid: range check, squares,
// radicand, 18 square-root stages, 20 CORDIC stages, output.
// Throughput: one word per cycle; the whole pipeline holds while m_ is stalled.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
`default_nettype none

module arm_height_inverse_kinematics_unit import ahik_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [15:0] target_height
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [63:0]            m_tdata,   // [15:0] shoulder_angle, [31:16] elbow_angle,
                                              // [47:32] wrist_angle, [63:48] reach_offset
    output logic [1:0]             m_tuser,   // [1:0] status
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [LEN_W-1:0]  cfg_wdata
);

    logic [LEN_W-1:0] base_reg, l1_reg, elbow_reg, l2_reg, grip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= 16'd4096;
            l1_reg    <= 16'd2097;
            elbow_reg <= 16'd393;
            l2_reg    <= 16'd2032;
            grip_reg  <= 16'd2376;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BASE:  base_reg  <= cfg_wdata;
                CFG_LINK1: l1_reg    <= cfg_wdata;
                CFG_ELBOW: elbow_reg <= cfg_wdata;
                CFG_LINK2: l2_reg    <= cfg_wdata;
                CFG_GRIP:  grip_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    logic [M_W-1:0] m_len;
    assign m_len = {1'b0, l2_reg} + {1'b0, elbow_reg};

    // ---- stage 0: range check
    logic signed [19:0] dz, lo, z2, hi;
    side_t              side_next;

    always_comb begin
        dz = {{4{s_tdata[15]}}, s_tdata} - $signed({4'b0, base_reg});
        lo = dz + $signed({4'b0, l2_reg});
        z2 = dz - $signed({4'b0, l1_reg});
        hi = z2 - $signed({4'b0, l2_reg});
        side_next.tilt = (z2 <= 0);
        side_next.v    = '0;
        if (lo < 0) begin
            side_next.status = ST_BELOW;
        end else if (hi > 0) begin
            side_next.status = ST_ABOVE;
        end else begin
            side_next.status = ST_OK;
            side_next.v = side_next.tilt ? dz[V_W-1:0] : z2[V_W-1:0];
        end
    end

    logic  s0_vld_reg;
    side_t s0_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_side_reg <= side_next;
        end
    end

    // ---- stage 1: squares
    logic [LEN_W-1:0] sq_a;
    logic [V_W-1:0]   v_abs;
    logic             s1_vld_reg;
    side_t            s1_side_reg;
    logic [31:0]      p1_reg;
    logic [33:0]      p2_reg;
    logic [35:0]      p3_reg;

    assign sq_a  = s0_side_reg.tilt ? l1_reg : l2_reg;
    assign v_abs = s0_side_reg.v[V_W-1] ? V_W'(-s0_side_reg.v) : V_W'(s0_side_reg.v);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= s0_side_reg;
            p1_reg      <= sq_a * sq_a;
            p2_reg      <= s0_side_reg.tilt ? m_len * m_len : '0;
            p3_reg      <= v_abs * v_abs;
        end
    end

    // ---- stage 2: radicand, clamped at zero
    logic signed [RAD_W:0] rad_diff;
    logic                  s2_vld_reg;
    side_t                 s2_side_reg;
    logic [RAD_W-1:0]      rad_reg;

    assign rad_diff = $signed({5'b0, p1_reg}) + $signed({3'b0, p2_reg})
                    - $signed({1'b0, p3_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg <= s1_side_reg;
            rad_reg     <= rad_diff[RAD_W] ? '0 : rad_diff[RAD_W-1:0];
        end
    end

    // ---- square root and arctangents
    logic              sq_vld;
    side_t             sq_side;
    logic [ROOT_W-1:0] sq_root;

    ahik_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s2_vld_reg),
        .in_side  (s2_side_reg),
        .in_rad   (rad_reg),
        .out_valid(sq_vld),
        .out_side (sq_side),
        .out_root (sq_root)
    );

    logic               cd_vld;
    side_t              cd_side;
    logic [ROOT_W-1:0]  cd_w;
    logic signed [ZW-1:0] cd_za, cd_zb;

    ahik_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sq_vld),
        .in_side  (sq_side),
        .in_w     (sq_root),
        .l1       (l1_reg),
        .m        (m_len),
        .out_valid(cd_vld),
        .out_side (cd_side),
        .out_w    (cd_w),
        .out_za   (cd_za),
        .out_zb   (cd_zb)
    );

    // ---- output stage
    function automatic logic signed [ANG_W-1:0] sat16(input logic signed [V_W:0] x);
        logic signed [ANG_W-1:0] r;
        if (x > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[ANG_W-1:0];
        end
        return r;
    endfunction

    logic signed [ZW-1:0]          d;
    logic signed [ZW:0]            d_rnd;
    logic signed [ZW-ANG_DROP:0]   q;
    logic signed [ANG_W-1:0]       a, a_neg;
    logic [V_W:0]                  reach_sum;
    logic [ANG_W-1:0]              reach_sat;

    logic [1:0]        status_reg;
    logic [ANG_W-1:0]  shoulder_reg, elbow_out_reg, wrist_reg, reach_reg;

    always_comb begin
        d     = cd_side.tilt ? cd_za - cd_zb : cd_zb;
        d_rnd = {d[ZW-1], d} + (ZW+1)'(64);
        q     = (ZW-ANG_DROP+1)'(d_rnd >>> ANG_DROP);
        a     = sat16((V_W+1)'(q));
        a_neg = sat16(-{{(V_W+1-ANG_W){a[ANG_W-1]}}, a});
        reach_sum = {1'b0, cd_w} + {3'b0, grip_reg}
                  + (cd_side.tilt ? '0 : {3'b0, elbow_reg});
        reach_sat = (reach_sum > 19'd32767) ? 16'h7fff : reach_sum[ANG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cd_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= cd_side.status;
            if (cd_side.status != ST_OK) begin
                shoulder_reg  <= '0;
                elbow_out_reg <= '0;
                wrist_reg     <= '0;
                reach_reg     <= '0;
            end else if (cd_side.tilt) begin
                shoulder_reg  <= a;
                elbow_out_reg <= '0;
                wrist_reg     <= a_neg;
                reach_reg     <= reach_sat;
            end else begin
                shoulder_reg  <= '0;
                elbow_out_reg <= a_neg;
                wrist_reg     <= a;
                reach_reg     <= reach_sat;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {reach_reg, wrist_reg, elbow_out_reg, shoulder_reg};

endmodule

`default_nettype wire

// ----- rtl/core/ahik_checker.sv -----
`default_nettype none

module ahik_checker import ahik_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [63:0]       m_tdata,
    input wire logic [1:0]        m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled word changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BELOW || m_tuser == ST_ABOVE))
        else $error("bad status code");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == 64'd0)
        else $error("nonzero payload on range error");

    a_one_joint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15:0] != 16'd0 |-> m_tdata[31:16] == 16'd0)
        else $error("shoulder and elbow both moved");

endmodule

bind arm_height_inverse_kinematics_unit ahik_checker u_ahik_checker (.*);

`default_nettype wire

// ----- bench/arm_height_inverse_kinematics_unit_checker.sv -----
`timescale 1ns / 1ps

module arm_height_inverse_kinematics_unit_checker import ahik_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [15:0]       s_tdata,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [63:0]       m_tdata,
    input  wire logic [1:0]        m_tuser,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [LEN_W-1:0]  cfg_wdata,
    output int                     error_count,
    output int                     pending_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] shoulder;
        logic [15:0] elbow;
        logic [15:0] wrist;
        logic [15:0] reach;
    } joint_cmd_t;

    longint base_h, link1, elbow_off, link2, grip;
    joint_cmd_t pending_cmds[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint root, bit_w;
        root = 0;
        bit_w = 64'sh4000_0000_0000_0000;
        if (n <= 0) return 0;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= root + bit_w) begin
                n = n - root - bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint cx, cy, nx, ny, z;
        z = 0;
        if (x == 0 && y == 0) return 0;
        cx = x <<< PRESCALE_SH;
        cy = y <<< PRESCALE_SH;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (cy == 0) break;
            if (cy > 0) begin
                nx = cx + floor_shr(cy, i);
                ny = cy - floor_shr(cx, i);
                z = z + longint'(atan_tab(i[4:0]));
            end else begin
                nx = cx - floor_shr(cy, i);
                ny = cy + floor_shr(cx, i);
                z = z - longint'(atan_tab(i[4:0]));
            end
            cx = nx;
            cy = ny;
        end
        return z;
    endfunction

    function automatic longint angle_q13(longint q20);
        return clamp16(floor_shr(q20 + 64, ANG_DROP));
    endfunction

    function automatic joint_cmd_t solve_height(logic [15:0] raw);
        joint_cmd_t r;
        longint h, dz, m, w, a, z2, d;
        r = '0;
        h = longint'($signed(raw));
        dz = h - base_h;
        if (h < base_h - link2) begin
            r.status = ST_BELOW;
        end else if (h > base_h + link1 + link2) begin
            r.status = ST_ABOVE;
        end else if (dz <= link1) begin
            m = link2 + elbow_off;
            d = link1 * link1 + m * m - dz * dz;
            w = floor_sqrt(d);
            a = angle_q13(vector_angle(link1, m) - vector_angle(dz, w));
            r.status = ST_OK;
            r.shoulder = a[15:0];
            r.wrist = 16'(clamp16(-a));
            r.reach = 16'(clamp16(w + grip));
        end else begin
            z2 = dz - link1;
            w = floor_sqrt(link2 * link2 - z2 * z2);
            a = angle_q13(vector_angle(z2, w));
            r.status = ST_OK;
            r.elbow = 16'(clamp16(-a));
            r.wrist = a[15:0];
            r.reach = 16'(clamp16(elbow_off + w + grip));
        end
        return r;
    endfunction

    assign pending_count = pending_cmds.size();

    always @(posedge aclk) begin
        joint_cmd_t want, got;
        if (!aresetn) begin
            base_h <= 4096;
            link1 <= 2097;
            elbow_off <= 393;
            link2 <= 2032;
            grip <= 2376;
            pending_cmds.delete();
            error_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BASE:  base_h <= longint'(cfg_wdata);
                    CFG_LINK1: link1 <= longint'(cfg_wdata);
                    CFG_ELBOW: elbow_off <= longint'(cfg_wdata);
                    CFG_LINK2: link2 <= longint'(cfg_wdata);
                    CFG_GRIP:  grip <= longint'(cfg_wdata);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_cmds.push_back(solve_height(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48]};
                if (pending_cmds.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    error_count <= error_count + 1;
                end else begin
                    want = pending_cmds.pop_front();
                    if (want !== got) begin
                        $display("%0t: mismatch expected st=%0d sh=%h el=%h wr=%h re=%h",
                                 $time, want.status, want.shoulder, want.elbow, want.wrist,
                                 want.reach);
                        $display("%0t:          actual   st=%0d sh=%h el=%h wr=%h re=%h",
                                 $time, got.status, got.shoulder, got.elbow, got.wrist,
                                 got.reach);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/arm_height_inverse_kinematics_unit_test.sv -----
`timescale 1ns / 1ps

module arm_height_inverse_kinematics_unit_test;
    import ahik_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [63:0]       m_tdata;   // [15:0] shoulder, [31:16] elbow, [47:32] wrist, [63:48] reach
    logic [1:0]        m_tuser;   // [1:0] status
    logic              cfg_wr_en;
    logic [2:0]        cfg_index;
    logic [LEN_W-1:0]  cfg_wdata;
    int                error_count;
    int                pending_count;
    int                cycle_count;
    bit                idle_on;
    bit                long_hold;

    arm_height_inverse_kinematics_unit dut (.*);

    arm_height_inverse_kinematics_unit_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("arm_height_inverse_kinematics_unit verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off
    initial begin
        int n;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                long_hold = 0;
                m_tready <= 1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                m_tready <= 0;
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic send_height(logic [15:0] h);
        int n;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= h;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic set_arm(logic [15:0] b, logic [15:0] l1, logic [15:0] e,
                           logic [15:0] l2, logic [15:0] g);
        write_reg(CFG_BASE, b);
        write_reg(CFG_LINK1, l1);
        write_reg(CFG_ELBOW, e);
        write_reg(CFG_LINK2, l2);
        write_reg(CFG_GRIP, g);
    endtask

    // mostly heights inside the working range, some anywhere
    function automatic logic [15:0] pick_height(int b, int l1, int l2);
        int lo, hi;
        lo = b - l2 - 4;
        hi = b + l1 + l2 + 4;
        if (lo < -32768) lo = -32768;
        if (hi > 32767) hi = 32767;
        if ($urandom_range(0, 4) == 0 || lo > hi) return 16'($urandom);
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    initial begin
        int b, l1, e, l2, g;
        s_tvalid = 0;
        s_tdata = 0;
        cfg_wr_en = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        idle_on = 0;
        long_hold = 0;
        cycle_count = 0;
        aresetn = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: default arm, limits and both cases
        send_height(16'h8000); send_height(16'h7fff); send_height(16'h0000);
        send_height(16'hffff); send_height(16'd2063); send_height(16'd2064);
        send_height(16'd4096); send_height(16'd6193); send_height(16'd6194);
        send_height(16'd8225); send_height(16'd8226); send_height(16'd5000);
        drain_results();
        // zero lengths: zero vector case
        set_arm(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_reg(3'd7, 16'hffff);
        send_height(16'd0); send_height(16'd1); send_height(16'hffff);
        drain_results();
        // reach overflow, large lengths
        set_arm(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_height(16'h7fff); send_height(16'h8000);
        drain_results();
        set_arm(16'd0, 16'd8000, 16'd30000, 16'd8000, 16'd20000);
        send_height(16'd0); send_height(16'd8000); send_height(16'd16000);
        send_height(16'hf000); send_height(16'h0fff);
        drain_results();

        idle_on = 1;
        for (int phase = 0; phase < 12; phase++) begin
            b = $urandom_range(0, 12000);
            l1 = $urandom_range(0, 9000);
            e = $urandom_range(0, 3000);
            l2 = $urandom_range(0, 9000);
            g = $urandom_range(0, 6000);
            if (phase == 3) begin
                b = 65535; l1 = 65535; e = 65535; l2 = 65535; g = 65535;
            end
            if (phase == 11) idle_on = 0;
            set_arm(16'(b), 16'(l1), 16'(e), 16'(l2), 16'(g));
            if (phase == 5) long_hold = 1;
            for (int k = 0; k < 150; k++) send_height(pick_height(b, l1, l2));
            drain_results();
        end

        repeat (60) @(posedge aclk);
        if (error_count == 0 && pending_count == 0)
            $display("arm_height_inverse_kinematics_unit verification clean");
        else
            $display("arm_height_inverse_kinematics_unit verification failed");
        $finish;
    end

endmodule
